FILE: src/rtc_pkg.sv
// Package for the reflexive transitive closure block.
// Holds the fixed row width, the row index width and the lane control struct.
// No dependencies.
package rtc_pkg;

   localparam int RowBits = 16;
   localparam int RowIdxBits = 4;
   localparam int CountBits = 5;

   typedef logic [RowBits-1:0] row_type;
   typedef logic [RowIdxBits-1:0] row_idx_type;
   typedef logic [CountBits-1:0] count_type;

   // Control that the sequencer broadcasts to every lane.
   typedef struct packed {
      logic        load;
      row_idx_type load_idx;
      row_type     load_row;
      logic        sweep;
      row_idx_type pivot;
      row_type     pivot_row;
   } rtc_lane_ctl_type;

endpackage

FILE: src/rtc_if.sv
// Request and response channel interfaces of the closure block.
// Depends on rtc_pkg for the row and index types.
interface rtc_req_if;
   import rtc_pkg::*;
   logic    valid;
   logic    ready;
   row_type adjacency_row;
   modport source (output valid, output adjacency_row, input ready);
   modport sink (input valid, input adjacency_row, output ready);
endinterface

interface rtc_rsp_if;
   import rtc_pkg::*;
   logic        valid;
   logic        ready;
   row_type     reach_row;
   row_idx_type row_number;
   logic        last_row;
   modport source (output valid, output reach_row, output row_number, output last_row,
                   input ready);
   modport sink (input valid, input reach_row, input row_number, input last_row,
                 output ready);
endinterface

FILE: src/rtc_lane.sv
// One closure lane: holds one row of the matrix and applies the pivot update.
// Depends on rtc_pkg for the row types and the lane control struct.
module rtc_lane #(
   parameter int LANE_ID = 0
) (
   input  logic                      clock,
   input  rtc_pkg::rtc_lane_ctl_type ctl,
   output rtc_pkg::row_type          row
);
   import rtc_pkg::*;

   localparam row_idx_type LaneIdx = RowIdxBits'(LANE_ID);

   row_type row_ff;
   row_type row_in;

   // The diagonal bit is set as the row is written, so each vertex reaches itself.
   always_comb begin
      row_in = row_ff;
      if (ctl.load && (ctl.load_idx == LaneIdx)) begin
         row_in = ctl.load_row | (row_type'(1) << LaneIdx);
      end else if (ctl.sweep && row_ff[ctl.pivot]) begin
         row_in = row_ff | ctl.pivot_row;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign row = row_ff;

endmodule

FILE: src/rtc_merge.sv
// Row selector that merges the lane outputs into the one row picked by index.
// Depends on rtc_pkg for the row types.
module rtc_merge #(
   parameter int LANES = 16
) (
   input  rtc_pkg::row_type     rows [LANES],
   input  rtc_pkg::row_idx_type sel,
   output rtc_pkg::row_type     row
);
   import rtc_pkg::*;

   always_comb begin
      row = '0;
      for (int i = 0; i < LANES; i++) begin
         if (sel == RowIdxBits'(i)) begin
            row = row | rows[i];
         end
      end
   end

endmodule

FILE: src/reflexive_transitive_closure_top.sv
// Reflexive transitive closure engine, top level (lanes, selectors, sequencer).
// Flow: n load requests, one per cycle while the source holds valid, then a sweep
// over n pivots, then n responses; a new graph is taken only after the last response;
// the pivot counter of the sweep sets the compute time, one pivot per cycle over all lanes.
// Reset (synchronous, active high) returns to loading with a vertex count of 16.
// Depends on rtc_pkg, rtc_if, rtc_lane and rtc_merge.
module reflexive_transitive_closure_top #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   rtc_req_if.sink               req_bus,
   rtc_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  rtc_pkg::count_type    csr_wr_data
);
   import rtc_pkg::*;

   // The row is 16 bits wide, so at most 16 vertices are ever in use.
   localparam int Lanes = (MAX_VERTICES < RowBits) ? MAX_VERTICES : RowBits;
   localparam int IdxBits = $clog2(Lanes);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SWEEP,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   count_type            vertex_count_ff;
   logic [IdxBits-1:0]   load_idx_ff;
   logic [IdxBits-1:0]   pivot_ff;
   logic [IdxBits-1:0]   emit_idx_ff;

   count_type            active_n;
   count_type            last_idx;
   row_type              row_mask;
   logic                 req_fire;
   logic                 rsp_fire;
   rtc_lane_ctl_type     lane_ctl;
   row_type              lane_rows [Lanes];
   row_type              pivot_row;
   row_type              emit_row;

   // A count of zero acts as one vertex; a count above the lane count saturates.
   always_comb begin
      if (vertex_count_ff == '0) begin
         active_n = CountBits'(1);
      end else if (vertex_count_ff > CountBits'(Lanes)) begin
         active_n = CountBits'(Lanes);
      end else begin
         active_n = vertex_count_ff;
      end
      last_idx = active_n - CountBits'(1);
      row_mask = RowBits'(({1'b0, row_type'('1)} >> (RowBits - 32'(active_n))));
   end

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;

   // Every lane sees the same control word; each one decides from its own id
   // whether a load is meant for it, and from its own pivot bit whether to merge.
   always_comb begin
      lane_ctl.load      = req_fire;
      lane_ctl.load_idx  = RowIdxBits'(load_idx_ff);
      lane_ctl.load_row  = req_bus.adjacency_row & row_mask;
      lane_ctl.sweep     = (state_ff == ST_SWEEP);
      lane_ctl.pivot     = RowIdxBits'(pivot_ff);
      lane_ctl.pivot_row = pivot_row;
   end

   for (genvar g = 0; g < Lanes; g++) begin : g_lane
      rtc_lane #(
         .LANE_ID (g)
      ) u_lane (
         .clock (clock),
         .ctl   (lane_ctl),
         .row   (lane_rows[g])
      );
   end

   // The pivot row does not change during its own step because its diagonal
   // bit is set, so all lanes may update from it in the same cycle.
   rtc_merge #(
      .LANES (Lanes)
   ) u_pivot_sel (
      .rows (lane_rows),
      .sel  (RowIdxBits'(pivot_ff)),
      .row  (pivot_row)
   );

   rtc_merge #(
      .LANES (Lanes)
   ) u_emit_sel (
      .rows (lane_rows),
      .sel  (RowIdxBits'(emit_idx_ff)),
      .row  (emit_row)
   );

   // Sequencer: load rows, sweep pivots, emit the closure rows.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         vertex_count_ff <= CountBits'(16);
         load_idx_ff     <= '0;
         pivot_ff        <= '0;
         emit_idx_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            vertex_count_ff <= csr_wr_data;
            load_idx_ff     <= '0;
         end
         case (state_ff)
            ST_LOAD: begin
               if (req_fire && !csr_wr_en) begin
                  if (CountBits'(load_idx_ff) == last_idx) begin
                     load_idx_ff <= '0;
                     pivot_ff    <= '0;
                     state_ff    <= ST_SWEEP;
                  end else begin
                     load_idx_ff <= load_idx_ff + IdxBits'(1);
                  end
               end
            end
            ST_SWEEP: begin
               if (CountBits'(pivot_ff) == last_idx) begin
                  pivot_ff    <= '0;
                  emit_idx_ff <= '0;
                  state_ff    <= ST_EMIT;
               end else begin
                  pivot_ff <= pivot_ff + IdxBits'(1);
               end
            end
            ST_EMIT: begin
               if (rsp_fire) begin
                  if (CountBits'(emit_idx_ff) == last_idx) begin
                     emit_idx_ff <= '0;
                     state_ff    <= ST_LOAD;
                  end else begin
                     emit_idx_ff <= emit_idx_ff + IdxBits'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   // The rows sit in lane registers, so the response payload is stable while
   // the sink stalls.
   assign req_bus.ready      = (state_ff == ST_LOAD);
   assign rsp_bus.valid      = (state_ff == ST_EMIT);
   assign rsp_bus.reach_row  = emit_row;
   assign rsp_bus.row_number = RowIdxBits'(emit_idx_ff);
   assign rsp_bus.last_row   = (CountBits'(emit_idx_ff) == last_idx);

   // Loading and emitting never overlap.
   assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request and response sides active together");

   // The final load of a graph starts the sweep at pivot zero.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !csr_wr_en && CountBits'(load_idx_ff) == last_idx)
      |=> (state_ff == ST_SWEEP && pivot_ff == '0))
      else $error("sweep did not start after the last row");

   // A response marked last carries the highest active row number.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.last_row) |-> (CountBits'(rsp_bus.row_number) == last_idx))
      else $error("last row flag on wrong row");

endmodule
